/* hdl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       wr_byte;      // write data into buffer at fill pointer
    logic [7:0] wr_data;
    logic       pad_step;     // write a padding byte at fill pointer
    logic [7:0] pad_data;
    logic       cnt_inc;      // advance byte count
    logic       load_w;       // start compression: load working vars, reset round count
    logic       round;        // run one round
    logic       fold;         // add working vars into hash
    logic       clear;        // return to initial state
  } cmd_t;

  typedef struct packed {
    logic [5:0]  fill;        // bytes in current block
    logic [63:0] bits;        // message length in bits
  } stat_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* hdl/sha256_stream_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Input channel: one request carries data_byte, has_byte and end_of_message,
// taken when in_valid is high and in_stall low.
// The 64th byte of a block starts compression: a load step, 64 rounds
// through the single round unit and a fold step, during all of which
// in_stall is high. An end request pads the block byte by byte (up to
// 64 pad bytes per block, one or two compressions), then emits eight digest
// words, index 0 first, last_word set on index 7, through out_valid/out_stall.
// Each word sits in an output register; a stalled word holds until taken.
// After the last word the hash returns to its initial values and fill and byte count clear.
// Reset (rst, synchronous) clears control state and loads the initial hash
// words; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::cmd_t  cmd;
  sha256_pkg::stat_t stat;
  logic [2:0]        rd_sel;
  sha256_pkg::word_t rd_word;
  logic              load_out;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst), .data_byte(data_byte), .has_byte(has_byte),
    .end_of_message(end_of_message), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .stat(stat), .rd_sel(rd_sel), .out_valid(out_valid),
    .out_stall(out_stall), .word_index(word_index), .last_word(last_word),
    .load_out(load_out)
  );

  sha256_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .rd_sel(rd_sel), .rd_word(rd_word)
  );

  always_ff @(posedge clk) begin
    if (load_out) digest_word <= rd_word;
  end

endmodule

/* hdl/sha256_dp.sv */
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: message block in the schedule window, one round per cycle, hash.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::cmd_t       cmd,
  output sha256_pkg::stat_t      stat,
  input  logic [2:0]             rd_sel,
  output sha256_pkg::word_t      rd_word
);

  logic [5:0]        fill;
  logic [63:0]       byte_count;
  sha256_pkg::word_t w [16];
  sha256_pkg::word_t hash [8];
  sha256_pkg::word_t v [8];
  logic [5:0]        rnd;

  sha256_pkg::word_t w_new, t1, t2;
  logic [7:0]        byte_in;
  logic [4:0]        lane_lsb;

  always_comb begin
    w_new = sha256_pkg::ssig1(w[14]) + w[9] + sha256_pkg::ssig0(w[1]) + w[0];
    t1 = v[7] + sha256_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
         sha256_pkg::RoundK[rnd] + w[0];
    t2 = sha256_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    byte_in = cmd.wr_byte ? cmd.wr_data : cmd.pad_data;
    // byte 0 of a word is its most significant byte
    lane_lsb = 5'd24 - {fill[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      byte_count <= '0;
    end else begin
      if (cmd.wr_byte || cmd.pad_step) fill <= fill + 6'd1;
      if (cmd.cnt_inc) byte_count <= byte_count + 64'd1;
    end
  end

  // Fill the block straight into the 16-word window, then run it as a
  // shift window during rounds; w[0] is the current round word.
  always_ff @(posedge clk) begin
    if (cmd.wr_byte || cmd.pad_step) begin
      w[fill[5:2]][lane_lsb +: 8] <= byte_in;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.load_w) begin
      rnd <= '0;
    end else if (cmd.round) begin
      rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_w) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::InitHash[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

  assign stat.fill = fill;
  assign stat.bits = {byte_count[60:0], 3'b000};
  assign rd_word   = hash[rd_sel];

endmodule

/* hdl/sha256_ctrl.sv */
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: input handshake, padding sequence, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                has_byte,
  input  logic                end_of_message,
  input  logic                in_valid,
  output logic                in_stall,
  output sha256_pkg::cmd_t    cmd,
  input  sha256_pkg::stat_t   stat,
  output logic [2:0]          rd_sel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          word_index,
  output logic                last_word,
  output logic                load_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;
  logic       closing, closing_next;   // message end pending
  logic       pad_first;               // next pad byte is 0x80
  logic       len_block;               // current pad block carries the length
  logic [5:0] rcount;
  logic [2:0] widx;
  logic       take;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign rd_sel   = widx;

  // Out register can load when empty or being drained.
  assign load_out = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    cmd = '0;
    cmd.wr_data = data_byte;
    cmd.pad_data = pad_first ? sha256_pkg::PadByte :
                   (stat.fill >= sha256_pkg::LenStart && len_block) ?
                   stat.bits[8*(7 - (stat.fill - sha256_pkg::LenStart)) +: 8] : 8'h00;
    state_next = state;
    closing_next = closing;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.wr_byte = has_byte;
          cmd.cnt_inc = has_byte;
          if (end_of_message) closing_next = 1'b1;
          // a byte that completes the block is compressed before padding
          if (has_byte && stat.fill == 6'd63) begin
            state_next = S_LOAD;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad_step = 1'b1;
        if (stat.fill == 6'd63) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_w = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rcount == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!closing) state_next = S_IDLE;
        else if (!len_block) state_next = S_PAD;
        else state_next = S_EMIT;
      end
      S_EMIT: begin
        if (load_out && widx == 3'd7) begin
          state_next = S_IDLE;
          closing_next = 1'b0;
          cmd.clear = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      closing <= 1'b0;
      pad_first <= 1'b0;
      len_block <= 1'b0;
      rcount <= '0;
      widx <= '0;
    end else begin
      state <= state_next;
      closing <= closing_next;
      if (state == S_IDLE && take && end_of_message) begin
        pad_first <= 1'b1;
        // fill after the optional byte write
        len_block <= ((stat.fill + {5'd0, has_byte}) < 6'd56) &&
                     !(has_byte && stat.fill == 6'd63);
      end else if (state == S_PAD) begin
        pad_first <= 1'b0;
      end
      if (state == S_FOLD && closing) len_block <= 1'b1;
      if (state == S_LOAD) rcount <= '0;
      else if (state == S_ROUND) rcount <= rcount + 6'd1;
      if (load_out) widx <= widx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      word_index <= widx;
      last_word <= (widx == 3'd7);
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> in_stall) else $error("input open during rounds");
  a_round_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> $past(rcount) == 6'd63) else $error("short compression");
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (state == S_EMIT && widx == 3'd7)) else $error("early clear");

endmodule

/* tb/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the stream hasher, computes the SHA-256 digest of
// every accepted message on its own, and compares each emitted digest word
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] chain [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  fill;
  logic [63:0] msg_bytes;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::InitHash[i];
    fill = '0;
    msg_bytes = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic absorb_request(input logic [7:0] b, input logic hb, input logic eom);
    int p;
    logic [63:0] bits;
    digest_word_t dw;
    if (hb) begin
      msg_block[fill] = b;
      fill++;
      msg_bytes++;
      if (fill == 0) compress();
    end
    if (!eom) return;
    p = fill;
    msg_block[p] = sha256_pkg::PadByte;
    p++;
    if (p > 56) begin
      while (p < 64) begin
        msg_block[p] = 8'h00;
        p++;
      end
      compress();
      p = 0;
    end
    while (p < 56) begin
      msg_block[p] = 8'h00;
      p++;
    end
    bits = msg_bytes << 3;
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      dw.word = chain[i];
      dw.idx = 3'(i);
      dw.last = (i == 7);
      digest_q.push_back(dw);
    end
    restart_message();
  endtask

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      fail_count = 0;
      restart_message();
      digest_q.delete();
    end else begin
      if (in_valid && !in_stall) absorb_request(data_byte, has_byte, end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest word %h", digest_word);
        end else begin
          exp_w = digest_q.pop_front();
          if (digest_word !== exp_w.word || word_index !== exp_w.idx
              || last_word !== exp_w.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                       exp_w.word, exp_w.idx, exp_w.last,
                       digest_word, word_index, last_word);
          end
        end
      end
    end
  end

endmodule

/* tb/tb_sha256_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_unit
// Drives byte-stream messages of many lengths (empty, pad boundaries, multi
// block) with random idling and stalls; the checker predicts every digest.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_unit;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 300;
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  logic start_hold = 1'b0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  sha256_stream_hasher_unit dut (.*);

  sha256_digest_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: long hold-off takes priority over random stalling
  always @(posedge clk) begin
    if (start_hold) begin
      out_stall <= 1'b1;
      hold_off <= HoldCycles;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // offer one request; hold it until taken
  task automatic send_request(input logic [7:0] b, input logic hb, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_line();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // bytes with random content; a bare end marker closes when bare_end is set or len is 0
  task automatic send_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    if (bare_end || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    release_line();
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, extreme bytes, idle item
    send_message(0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    wait_drained();
    // pad spills into a second block; last byte fills the block with the end
    send_message(56, 1'b1);
    send_message(64, 1'b0);

    // long receiver hold-off while bytes keep coming
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    send_message(3, 1'b0);
    send_message(2, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int m = 0; m < 2; m++) begin
        len = $urandom_range(4);
        send_message(len, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    release_line();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
